// ----- rtl/pbf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pbf_pkg;

  localparam logic [7:0] OPEN_CH  = 8'h28;
  localparam logic [7:0] CLOSE_CH = 8'h29;

  localparam int QUEUE_DEPTH = 4;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_OPEN  = 2'd1,
    CLS_CLOSE = 2'd2
  } cls_t;

  // One classified transaction passed from front to back.
  typedef struct packed {
    logic [7:0] ch;
    cls_t       cls;
    logic       last;
    logic       drop;   // no room left, not stored
    logic       trunc;  // string has lost bytes so far
  } item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } qstat_t;

endpackage

`default_nettype wire

// ----- rtl/paren_balance_filter.sv -----
// Channel   Handshake            Payload
// input     in_valid / in_stall  in_char, in_last
// output    out_valid/out_stall  out_char, out_empty, out_last, out_truncated
//
// Loading takes each byte in ST_LOAD; a ')' that closes an open bracket also passes
// through ST_MARK (the stack memory's registered read feeds the keep write there).
// After the last byte, emission walks the text memory through its single read port,
// each stored byte through ST_RD and ST_CHK, then the final transaction in ST_FLUSH.
// Reset clears all control state; stores need no clearing.
// A four-entry queue lets the front take bytes of the next string during emission.
`timescale 1ns / 1ps
`default_nettype none

module paren_balance_filter #(
  parameter int MAX_LEN = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_char,
  output logic            out_empty,
  output logic            out_last,
  output logic            out_truncated
);

  pbf_pkg::qstat_t qstat;
  pbf_pkg::item_t  push_item;
  pbf_pkg::item_t  head;
  logic            push;
  logic            pop;

  pbf_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_char  (in_char),
    .in_last  (in_last),
    .qstat    (qstat),
    .push     (push),
    .item     (push_item)
  );

  pbf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .qstat     (qstat),
    .head      (head)
  );

  pbf_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .qstat         (qstat),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .out_empty     (out_empty),
    .out_last      (out_last),
    .out_truncated (out_truncated)
  );

endmodule

`default_nettype wire

// ----- rtl/pbf_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pbf_front #(
  parameter int MAX_LEN = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_char,
  input  wire logic          in_last,
  input  wire pbf_pkg::qstat_t qstat,
  output logic               push,
  output pbf_pkg::item_t     item
);

  localparam int CW = $clog2(MAX_LEN + 1);

  logic [CW-1:0] count;
  logic          ovf;
  logic          accept;
  logic          drop;

  assign in_stall = qstat.full;
  assign accept   = in_valid && !in_stall;
  assign drop     = (count >= CW'(MAX_LEN));
  // dropped bytes only travel when they close the string
  assign push     = accept && (!drop || in_last);

  always_comb begin
    item.ch    = in_char;
    item.last  = in_last;
    item.drop  = drop;
    item.trunc = ovf || drop;
    if (in_char == pbf_pkg::OPEN_CH) begin
      item.cls = pbf_pkg::CLS_OPEN;
    end else if (in_char == pbf_pkg::CLOSE_CH) begin
      item.cls = pbf_pkg::CLS_CLOSE;
    end else begin
      item.cls = pbf_pkg::CLS_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        count <= '0;
        ovf   <= 1'b0;
      end else if (drop) begin
        ovf <= 1'b1;
      end else begin
        count <= count + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pbf_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pbf_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire pbf_pkg::item_t  push_item,
  input  wire logic            pop,
  output pbf_pkg::qstat_t      qstat,
  output pbf_pkg::item_t       head
);

  pbf_pkg::item_t                slots [pbf_pkg::QUEUE_DEPTH];
  logic [pbf_pkg::QIDX_W-1:0]    wr_ptr;
  logic [pbf_pkg::QIDX_W-1:0]    rd_ptr;
  logic [pbf_pkg::QCNT_W-1:0]    count;
  logic                          do_push;
  logic                          do_pop;

  assign qstat.valid = (count != '0);
  assign qstat.full  = (count == pbf_pkg::QCNT_W'(pbf_pkg::QUEUE_DEPTH));
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && qstat.valid;
  assign head        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pbf_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pbf_back #(
  parameter int MAX_LEN = 64
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire pbf_pkg::qstat_t qstat,
  input  wire pbf_pkg::item_t  head,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [7:0]           out_char,
  output logic                 out_empty,
  output logic                 out_last,
  output logic                 out_truncated
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_MARK  = 5'b00010,
    ST_RD    = 5'b00100,
    ST_CHK   = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_t;

  typedef struct packed {
    logic       keep;
    logic [7:0] ch;
  } entry_t;

  entry_t        txt_mem [MAX_LEN];
  entry_t        txt_rdata;
  entry_t        txt_wdata;
  logic          txt_we;
  logic [PW-1:0] txt_waddr;

  logic [PW-1:0] stk_mem [MAX_LEN];
  logic [PW-1:0] stk_rdata;
  logic          stk_we;
  logic [CW-1:0] depth_dec;

  state_t        state;
  state_t        state_next;
  logic [CW-1:0] len;
  logic [CW-1:0] depth;
  logic [CW-1:0] idx;
  logic          held_last;
  logic          trunc;
  logic          have_pend;
  logic [7:0]    pend_ch;

  logic          in_item;
  logic          matched;
  logic          out_free;
  logic          out_load;
  logic          chk_done;

  assign in_item   = (state == ST_LOAD) && qstat.valid;
  assign pop       = in_item;
  assign matched   = (head.cls == pbf_pkg::CLS_CLOSE) && (depth != '0);
  assign out_free  = !out_valid || !out_stall;
  assign depth_dec = depth - 1'b1;
  assign stk_we    = in_item && !head.drop && (head.cls == pbf_pkg::CLS_OPEN);
  // a kept byte can only leave once the next one is found, so the last flag is known
  assign chk_done  = (state == ST_CHK) && !(txt_rdata.keep && have_pend && !out_free);
  assign out_load  = ((state == ST_CHK) && txt_rdata.keep && have_pend && out_free) ||
                     ((state == ST_FLUSH) && out_free);

  always_comb begin
    txt_we    = 1'b0;
    txt_waddr = len[PW-1:0];
    txt_wdata.ch   = head.ch;
    txt_wdata.keep = (head.cls == pbf_pkg::CLS_OTHER) || matched;
    if (in_item && !head.drop) begin
      txt_we = 1'b1;
    end else if (state == ST_MARK) begin
      txt_we         = 1'b1;
      txt_waddr      = stk_rdata;
      txt_wdata.ch   = pbf_pkg::OPEN_CH;
      txt_wdata.keep = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (txt_we) begin
      txt_mem[txt_waddr] <= txt_wdata;
    end
    txt_rdata <= txt_mem[idx[PW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[depth[PW-1:0]] <= len[PW-1:0];
    end
    stk_rdata <= stk_mem[depth_dec[PW-1:0]];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (qstat.valid) begin
          if (!head.drop && matched) begin
            state_next = ST_MARK;
          end else if (head.last) begin
            state_next = ST_RD;
          end
        end
      end
      ST_MARK: begin
        state_next = held_last ? ST_RD : ST_LOAD;
      end
      ST_RD: begin
        state_next = ST_CHK;
      end
      ST_CHK: begin
        if (chk_done) begin
          state_next = (idx + 1'b1 == len) ? ST_FLUSH : ST_RD;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      len       <= '0;
      depth     <= '0;
      idx       <= '0;
      held_last <= 1'b0;
      trunc     <= 1'b0;
      have_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_item) begin
        held_last <= head.last;
        trunc     <= head.trunc;
        idx       <= '0;
        if (!head.drop) begin
          len <= len + 1'b1;
          if (head.cls == pbf_pkg::CLS_OPEN) begin
            depth <= depth + 1'b1;
          end else if (matched) begin
            depth <= depth_dec;
          end
        end
      end
      if (chk_done) begin
        idx <= idx + 1'b1;
        if (txt_rdata.keep) begin
          have_pend <= 1'b1;
        end
      end
      if ((state == ST_FLUSH) && out_free) begin
        len       <= '0;
        depth     <= '0;
        have_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chk_done && txt_rdata.keep) begin
      pend_ch <= txt_rdata.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_truncated <= trunc;
      if (state == ST_FLUSH) begin
        out_char  <= have_pend ? pend_ch : 8'h00;
        out_empty <= !have_pend;
        out_last  <= 1'b1;
      end else begin
        out_char  <= pend_ch;
        out_empty <= 1'b0;
        out_last  <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pbf_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pbf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_char,
  input wire logic       out_empty,
  input wire logic       out_last
);

  // empty result is a lone, zeroed final transaction
  a_empty_is_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_empty |-> out_last && (out_char == 8'h00))
    else $error("empty result not final or not zero");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("stalled output changed");

endmodule

bind paren_balance_filter pbf_checker u_pbf_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_char  (out_char),
  .out_empty (out_empty),
  .out_last  (out_last)
);

`default_nettype wire
